### hw/rtl/vsd_pkg.sv
package vsd_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_DECODE_MODE  = 2'd0;
   localparam logic [1:0] CSR_LIMIT_ENABLE = 2'd1;
   localparam logic [1:0] CSR_MAX_ITEMS    = 2'd2;

   localparam int CSR_DATA_W = 16;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 64;
   localparam int GROUP_W = 4;
   localparam int COUNT_W = 16;

   // groups past this count no longer land in the accumulator
   localparam logic [GROUP_W-1:0] GROUP_CAP = 4'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_UNSIGNED = 2'd0,
      MODE_SIGNED   = 2'd1,
      MODE_ZIGZAG   = 2'd2,
      MODE_RESERVED = 2'd3
   } decode_mode_type;

   typedef struct packed {
      decode_mode_type      decode_mode;
      logic                 limit_enable;
      logic [COUNT_W-1:0]   max_items;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [VALUE_W-1:0]   value;
      logic                 status;
      logic                 list_end;
   } result_type;

endpackage

### hw/rtl/vsd_in_stage.sv
module vsd_in_stage
   import vsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              req_tlast,
   input  logic              out_free,
   output logic              advance,
   output logic [BYTE_W-1:0] byte_out,
   output logic              last_out
);

   logic              in_vld_ff;
   logic              in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              take;

   // word moves on to the decoder when the result side can hold its result
   assign advance    = in_vld_ff & out_free;
   assign req_tready = ~in_vld_ff | out_free;
   assign take       = req_tvalid & req_tready;
   assign byte_out   = in_byte_ff;
   assign last_out   = in_last_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

endmodule

### hw/rtl/vsd_core.sv
module vsd_core
   import vsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              advance,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              buffer_end,
   output result_type        result
);

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [COUNT_W-1:0] items_ff, items_in;
   logic               hit_ff, hit_in;

   logic               hit_now;
   logic               group_open;
   logic [5:0]         shamt;
   logic [VALUE_W-1:0] acc_new;
   logic [VALUE_W-1:0] mode_value;
   logic [COUNT_W-1:0] items_inc;
   logic               done;
   logic               stop;

   // limit check against the count before this word
   assign hit_now    = hit_ff | (cfg.limit_enable & (items_ff >= cfg.max_items));
   assign group_open = group_ff < GROUP_CAP;
   assign shamt      = 6'({2'b00, group_ff} * 6'd7);
   assign done       = ~data_byte[BYTE_W-1];

   // place seven payload bits at the current group
   always_comb begin
      acc_new = acc_ff;
      if (group_open) begin
         acc_new = acc_ff | ({{(VALUE_W-7){1'b0}}, data_byte[6:0]} << shamt);
      end
   end

   // saturating value count
   assign items_inc = (items_ff == COUNT_MAX) ? items_ff : items_ff + 16'd1;
   assign stop      = cfg.limit_enable & (items_inc >= cfg.max_items);

   // zigzag undoes the sign fold, other modes pass the bits
   always_comb begin
      case (cfg.decode_mode)
         MODE_ZIGZAG: mode_value = (acc_new >> 1) ^ {VALUE_W{acc_new[0]}};
         MODE_UNSIGNED,
         MODE_SIGNED,
         MODE_RESERVED: mode_value = acc_new;
         default: mode_value = acc_new;
      endcase
   end

   // result for the word in flight
   always_comb begin
      result.valid    = advance & ~hit_now & (done | buffer_end);
      result.value    = done ? mode_value : '0;
      result.status   = ~done;
      result.list_end = done ? (buffer_end | stop) : 1'b1;
   end

   // next decoder state
   always_comb begin
      acc_in   = acc_ff;
      group_in = group_ff;
      items_in = items_ff;
      hit_in   = hit_ff;
      if (advance) begin
         if (buffer_end) begin
            acc_in   = '0;
            group_in = '0;
            items_in = '0;
            hit_in   = 1'b0;
         end else if (hit_now) begin
            hit_in = 1'b1;
         end else if (done) begin
            acc_in   = '0;
            group_in = '0;
            items_in = items_inc;
            hit_in   = stop;
         end else begin
            acc_in   = acc_new;
            group_in = group_open ? group_ff + 4'd1 : group_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         group_ff <= '0;
         items_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         group_ff <= group_in;
         items_ff <= items_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

### hw/rtl/vsd_out_stage.sv
module vsd_out_stage
   import vsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  result_type         result,
   output logic               out_free,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);

   logic               rsp_vld_ff, rsp_vld_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_status_ff;
   logic               rsp_last_ff;

   // room for a new result when empty or being drained this cycle
   assign out_free   = ~rsp_vld_ff | rsp_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (result.valid) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_value_ff  <= result.value;
         rsp_status_ff <= result.status;
         rsp_last_ff   <= result.list_end;
      end
   end

endmodule

### hw/rtl/varint_stream_decoder_unit.sv
// Varint stream decoder.
// The req_ channel carries one encoded byte per word, tlast on the final byte
// of a buffer. The rsp_ channel carries one decoded 64-bit value per word
// (tdata), an incomplete flag in tuser and tlast on the last value of the
// buffer. A continuation byte gives no rsp word unless it ends the buffer.
// The csr_ port writes decode mode, limit enable and item limit; write only
// while no bytes are in flight.
// Throughput is one byte per cycle while the receiver keeps up: an input
// register feeds a decode step of one shift and OR into the accumulator,
// and a result register follows. An accepted byte moves through the decode
// step into the result register, which drives rsp_tvalid, once it is free.
// When the receiver stalls, the result register holds its word and one more
// byte waits in the input register; req_tready then drops.
// Reset clears both valid flags, the accumulator, the group and value counts,
// the limit latch and the csr registers (unsigned mode, no limit).
module varint_stream_decoder_unit
   import vsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_W-1:0]    rsp_tdata,   // [63:0] value
   output logic                  rsp_tuser,   // [0] status
   output logic                  rsp_tlast,
   // configuration writes
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   decode_mode_type    mode_ff;
   logic               limit_en_ff;
   logic [COUNT_W-1:0] max_items_ff;
   cfg_type            cfg;

   logic               out_free;
   logic               advance;
   logic [BYTE_W-1:0]  cur_byte;
   logic               cur_last;
   result_type         result;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UNSIGNED;
         limit_en_ff  <= 1'b0;
         max_items_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DECODE_MODE:  mode_ff      <= decode_mode_type'(csr_wdata[1:0]);
            CSR_LIMIT_ENABLE: limit_en_ff  <= csr_wdata[0];
            CSR_MAX_ITEMS:    max_items_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.decode_mode  = mode_ff;
   assign cfg.limit_enable = limit_en_ff;
   assign cfg.max_items    = max_items_ff;

   vsd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_free   (out_free),
      .advance    (advance),
      .byte_out   (cur_byte),
      .last_out   (cur_last)
   );

   vsd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .advance    (advance),
      .data_byte  (cur_byte),
      .buffer_end (cur_last),
      .result     (result)
   );

   vsd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### tb/sv/varint_stream_decoder_unit_tb.sv
module varint_stream_decoder_unit_tb;
   import vsd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_BYTES   = 155;
   localparam int PRINT_CAP     = 40;
   // index with no register behind it, writes there are dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               status;
      logic               list_end;
   } varint_word_type;

   typedef enum logic {STEP_BYTE, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type   kind;
      logic [1:0]      csr_idx;
      logic [15:0]     operand;   // byte in [7:0], or csr data
      logic            last;
      logic            typed;     // want holds the word to expect
      varint_word_type want;
   } step_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [VALUE_W-1:0]    rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en  = 1'b0;
   logic [1:0]            csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   varint_stream_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // decoder shadow: registers and buffer state
   cfg_type            shadow_cfg  = '0;
   logic [VALUE_W-1:0] acc_bits    = '0;
   logic [GROUP_W-1:0] group_pos   = '0;
   logic [COUNT_W-1:0] value_count = '0;
   logic               stopped     = 1'b0;

   varint_word_type pending_words[$];

   int mismatches    = 0;
   int words_checked = 0;
   int incompletes   = 0;
   int bytes_sent    = 0;
   int bytes_taken   = 0;
   int buffers_sent  = 0;
   int csr_writes    = 0;
   int cycle_count   = 0;
   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int hold_token    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] seen,
                                  input logic [63:0] wanted);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("mismatch %s at word %0d: got %h want %h", what, words_checked, seen, wanted);
   endtask

   // one byte through the shadow decoder
   task automatic decode_step(input logic [7:0] data, input logic last,
                              output logic has_word, output varint_word_type word,
                              output logic taken);
      logic [VALUE_W-1:0] payload;
      logic               limit_now;
      has_word = 1'b0;
      word     = '0;
      if (shadow_cfg.limit_enable && value_count >= shadow_cfg.max_items)
         stopped = 1'b1;
      taken = !stopped;
      if (!stopped) begin
         payload = {57'd0, data[6:0]};
         // groups past the cap fall off the top
         if (group_pos < GROUP_CAP) begin
            acc_bits  = acc_bits | (payload << (7 * int'(group_pos)));
            group_pos = group_pos + 1'b1;
         end
         if (!data[7]) begin
            if (shadow_cfg.decode_mode == MODE_ZIGZAG)
               word.value = (acc_bits >> 1) ^ {VALUE_W{acc_bits[0]}};
            else
               word.value = acc_bits;
            if (value_count != COUNT_MAX)
               value_count = value_count + 1'b1;
            limit_now = shadow_cfg.limit_enable && value_count >= shadow_cfg.max_items;
            if (limit_now)
               stopped = 1'b1;
            word.list_end = last || limit_now;
            acc_bits  = '0;
            group_pos = '0;
            has_word  = 1'b1;
         end else if (last) begin
            word.status   = 1'b1;
            word.list_end = 1'b1;
            has_word      = 1'b1;
         end
      end
      if (last) begin
         acc_bits    = '0;
         group_pos   = '0;
         value_count = '0;
         stopped     = 1'b0;
      end
   endtask

   // offer one byte, wait for the handshake, then queue what it yields
   task automatic send_word(input logic [7:0] data, input logic last,
                            input logic typed, input varint_word_type fixed);
      logic            has_word;
      logic            taken;
      varint_word_type word;
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      decode_step(data, last, has_word, word, taken);
      bytes_sent++;
      if (taken)
         bytes_taken++;
      if (typed)
         word = fixed;
      if (typed || has_word) begin
         pending_words.push_back(word);
         if (word.status)
            incompletes++;
      end
   endtask

   // sender pauses until every word is out and the pipe is empty
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DECODE_MODE:  shadow_cfg.decode_mode  = decode_mode_type'(data[1:0]);
         CSR_LIMIT_ENABLE: shadow_cfg.limit_enable = data[0];
         CSR_MAX_ITEMS:    shadow_cfg.max_items    = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic randomize_config();
      logic [15:0] mode_data;
      logic [15:0] enable_data;
      logic [15:0] limit_data;
      mode_data        = 16'($urandom);
      mode_data[1:0]   = 2'($urandom_range(3));
      enable_data      = 16'($urandom);
      enable_data[0]   = ($urandom_range(2) == 0);
      case ($urandom_range(4))
         0:       limit_data = '0;
         1:       limit_data = COUNT_MAX;
         2:       limit_data = 16'($urandom);
         default: limit_data = 16'($urandom_range(1, 5));
      endcase
      csr_write(CSR_DECODE_MODE, mode_data);
      csr_write(CSR_LIMIT_ENABLE, enable_data);
      csr_write(CSR_MAX_ITEMS, limit_data);
   endtask

   // mostly well-formed varint buffers, some cut short, some plain noise
   task automatic send_random_buffer();
      logic [7:0] frame[$];
      logic [7:0] data;
      int         values;
      int         len;
      buffers_sent++;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
      end else begin
         values = $urandom_range(1, 6);
         repeat (values) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
               data    = 8'($urandom);
               data[7] = (k != len - 1);
               frame.push_back(data);
            end
         end
         // buffer ends inside a value
         if ($urandom_range(5) == 0)
            repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom) | 8'h80);
      end
      foreach (frame[j])
         send_word(frame[j], j == frame.size() - 1, 1'b0, '0);
   endtask

   function automatic step_type byte_step(input logic [7:0] data, input logic last);
      byte_step = '{STEP_BYTE, 2'd0, {8'd0, data}, last, 1'b0, '0};
   endfunction

   function automatic step_type typed_step(input logic [7:0] data, input logic last,
                                           input logic [63:0] value, input logic status,
                                           input logic list_end);
      typed_step = '{STEP_BYTE, 2'd0, {8'd0, data}, last, 1'b1, '{value, status, list_end}};
   endfunction

   function automatic step_type csr_step(input logic [1:0] idx, input logic [15:0] data);
      csr_step = '{STEP_CSR, idx, data, 1'b0, 1'b0, '0};
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen  <= hold_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // check each rsp word against the oldest expectation
   always @(posedge clock) begin : rsp_check
      varint_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, '0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata !== want.value)
               report_mismatch("value", rsp_tdata, want.value);
            if (rsp_tuser !== want.status)
               report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
            if (rsp_tlast !== want.list_end)
               report_mismatch("list_end", 64'(rsp_tlast), 64'(want.list_end));
         end
         words_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, pending_words.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      step_type        plan[36];
      varint_word_type leftover;
      int              phase_start;
      int              wait_cycles;

      plan = '{
         typed_step(8'h00, 1'b0, 64'd0, 1'b0, 1'b0),
         // longest value: ten full groups and one past the cap
         byte_step(8'hFF, 1'b0), byte_step(8'hFF, 1'b0), byte_step(8'hFF, 1'b0),
         byte_step(8'hFF, 1'b0), byte_step(8'hFF, 1'b0), byte_step(8'hFF, 1'b0),
         byte_step(8'hFF, 1'b0), byte_step(8'hFF, 1'b0), byte_step(8'hFF, 1'b0),
         byte_step(8'hFF, 1'b0), byte_step(8'h7F, 1'b0),
         // buffer ends inside a value
         typed_step(8'h80, 1'b1, 64'd0, 1'b1, 1'b1),
         typed_step(8'h05, 1'b1, 64'd5, 1'b0, 1'b1),
         csr_step(CSR_DECODE_MODE, 16'(MODE_ZIGZAG)),
         typed_step(8'h03, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0),
         typed_step(8'h04, 1'b1, 64'd2, 1'b0, 1'b1),
         csr_step(CSR_DECODE_MODE, 16'(MODE_SIGNED)),
         typed_step(8'h7F, 1'b1, 64'h7F, 1'b0, 1'b1),
         csr_step(CSR_DECODE_MODE, 16'(MODE_RESERVED)),
         typed_step(8'h03, 1'b1, 64'd3, 1'b0, 1'b1),
         // item limit of two, rest of the buffer dropped
         csr_step(CSR_DECODE_MODE, 16'(MODE_UNSIGNED)),
         csr_step(CSR_LIMIT_ENABLE, 16'd1),
         csr_step(CSR_MAX_ITEMS, 16'd2),
         typed_step(8'h01, 1'b0, 64'd1, 1'b0, 1'b0),
         typed_step(8'h02, 1'b0, 64'd2, 1'b0, 1'b1),
         byte_step(8'h03, 1'b0),
         byte_step(8'h04, 1'b1),
         // limit of zero swallows the whole buffer
         csr_step(CSR_MAX_ITEMS, 16'd0),
         byte_step(8'h01, 1'b1),
         // limit stays latched after it is switched off mid-buffer
         csr_step(CSR_MAX_ITEMS, 16'd1),
         typed_step(8'h09, 1'b0, 64'd9, 1'b0, 1'b1),
         csr_step(CSR_LIMIT_ENABLE, 16'd0),
         byte_step(8'h0A, 1'b1),
         csr_step(CSR_UNUSED, 16'hFFFF),
         typed_step(8'h0B, 1'b1, 64'd11, 1'b0, 1'b1)
      };

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed table
      tx_idle_pct = 24;
      rx_idle_pct = 81;
      foreach (plan[i]) begin
         if (plan[i].kind == STEP_CSR) begin
            drain_results();
            csr_write(plan[i].csr_idx, plan[i].operand);
         end else begin
            send_word(plan[i].operand[7:0], plan[i].last, plan[i].typed, plan[i].want);
         end
      end

      // random buffers, three idle patterns
      for (int ph = 0; ph < 3; ph++) begin
         drain_results();
         tx_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 81 : 0;
         rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 24 : 0;
         // long receiver hold-off while the sender keeps going
         hold_token++;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if ($urandom_range(2) == 0) begin
               drain_results();
               randomize_config();
            end
            send_random_buffer();
         end
      end

      // wait out the tail
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (pending_words.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      while (pending_words.size() != 0) begin
         leftover = pending_words.pop_front();
         report_mismatch("missing word", '0, leftover.value);
      end

      $display("%0d bytes (%0d decoded) in %0d buffers, %0d words checked (%0d incomplete)",
               bytes_sent, bytes_taken, buffers_sent, words_checked, incompletes);
      $display("%0d csr writes: all decode modes, item limits 0 to 65535, stalls on both sides",
               csr_writes);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
